// File: rtl/core/merge_insertion_sorter_assert.svh
// assertion macros shared by the sorter checker
// no dependencies
`ifndef MERGE_INSERTION_SORTER_ASSERT_SVH
`define MERGE_INSERTION_SORTER_ASSERT_SVH

// antecedent in this cycle implies consequent in this cycle
`define MSORT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msort check failed");

// antecedent in this cycle implies consequent in the next cycle
`define MSORT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msort check failed");

`endif

// File: rtl/core/msort_pkg.sv
// shared constants for the merge-insertion sorter
// no dependencies
package msort_pkg;
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 31;
endpackage

// File: rtl/core/merge_insertion_sorter.sv
// sorter top level: values are kept in one ram in ascending order, each new item
// inserted by walking down from the top through S_INS, then S_FIN if it goes to the bottom,
// the ram port pair doing one shift step per cycle; run output takes each item through S_ORD,
// S_OWAIT and S_OHOLD, and the next item is read only once the receiver has taken it.
// aresetn (sync, active low) clears count, overflow flag and handshake state.
// depends on msort_pkg and msort_ram
module merge_insertion_sorter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] in_value, [31] zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] out_value, [31] zero fill
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflow
);
    typedef enum logic [2:0] {
        S_LOAD, S_INS, S_FIN, S_ORD, S_OWAIT, S_OHOLD
    } state_t;

    state_t                          state_reg;
    logic [msort_pkg::CNT_W-1:0]     count_reg;
    logic                            ovf_reg;
    logic [msort_pkg::VAL_W-1:0]     val_reg;
    logic                            last_reg;
    logic [msort_pkg::ADDR_W-1:0]    k_reg;
    logic [msort_pkg::ADDR_W-1:0]    oidx_reg;
    logic                            mvalid_reg;
    logic [msort_pkg::VAL_W-1:0]     mval_reg;
    logic                            mlast_reg;
    logic                            muser_reg;

    logic                            we;
    logic [msort_pkg::ADDR_W-1:0]    waddr;
    logic [msort_pkg::VAL_W-1:0]     wdata;
    logic [msort_pkg::ADDR_W-1:0]    raddr;
    logic [msort_pkg::VAL_W-1:0]     rdata;
    logic                            s_acc;
    logic                            full;
    logic [msort_pkg::CNT_W-1:0]     cnt_m1;

    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign full     = (count_reg == msort_pkg::CNT_W'(msort_pkg::MAX_ITEMS));
    assign cnt_m1   = count_reg - msort_pkg::CNT_W'(1);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {1'b0, mval_reg};
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

    msort_ram #(.WIDTH(msort_pkg::VAL_W), .DEPTH(msort_pkg::MAX_ITEMS)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        we    = 1'b0;
        waddr = k_reg + msort_pkg::ADDR_W'(1);
        wdata = val_reg;
        raddr = k_reg;
        unique case (state_reg)
            S_LOAD: begin
                raddr = cnt_m1[msort_pkg::ADDR_W-1:0];
                if (s_acc && count_reg == '0) begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = s_tdata[msort_pkg::VAL_W-1:0];
                end
            end
            S_INS: begin
                we = 1'b1;
                // shift the larger entry up one place, else drop the value in
                if (rdata > val_reg) begin
                    wdata = rdata;
                    raddr = k_reg - msort_pkg::ADDR_W'(1);
                end
            end
            S_FIN: begin
                we    = 1'b1;
                waddr = '0;
            end
            S_ORD:   raddr = oidx_reg;
            S_OWAIT: raddr = oidx_reg;
            S_OHOLD: raddr = oidx_reg;
            default: raddr = k_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
            oidx_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (s_acc) begin
                        val_reg  <= s_tdata[msort_pkg::VAL_W-1:0];
                        last_reg <= s_tlast;
                        oidx_reg <= '0;
                        if (full) begin
                            ovf_reg <= 1'b1;
                            if (s_tlast) state_reg <= S_ORD;
                        end else if (count_reg == '0) begin
                            count_reg <= msort_pkg::CNT_W'(1);
                            if (s_tlast) state_reg <= S_ORD;
                        end else begin
                            k_reg     <= cnt_m1[msort_pkg::ADDR_W-1:0];
                            state_reg <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    if (rdata > val_reg) begin
                        if (k_reg == '0) begin
                            state_reg <= S_FIN;
                        end else begin
                            k_reg <= k_reg - msort_pkg::ADDR_W'(1);
                        end
                    end else begin
                        count_reg <= count_reg + msort_pkg::CNT_W'(1);
                        state_reg <= last_reg ? S_ORD : S_LOAD;
                    end
                end
                S_FIN: begin
                    count_reg <= count_reg + msort_pkg::CNT_W'(1);
                    state_reg <= last_reg ? S_ORD : S_LOAD;
                end
                S_ORD: state_reg <= S_OWAIT;
                S_OWAIT: begin
                    mvalid_reg <= 1'b1;
                    mval_reg   <= rdata;
                    mlast_reg  <= (msort_pkg::CNT_W'(oidx_reg) == cnt_m1);
                    muser_reg  <= ovf_reg;
                    state_reg  <= S_OHOLD;
                end
                S_OHOLD: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        if (mlast_reg) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end else begin
                            oidx_reg  <= oidx_reg + msort_pkg::ADDR_W'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule

// File: rtl/core/msort_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/msort_checker.sv
// port-level checks for the sorter, bound to the top level
// depends on merge_insertion_sorter_assert.svh
`include "merge_insertion_sorter_assert.svh"

module msort_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);
    // a result that is waiting stays offered
    `MSORT_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // no input is taken while a run is being delivered
    `MSORT_ASSERT_SAME(a_excl, aclk, aresetn, m_tvalid, !s_tready)
    // the end of a run frees the input side
    `MSORT_ASSERT_NEXT(a_end, aclk, aresetn, m_tvalid && m_tready && m_tlast,
        !m_tvalid && s_tready)
endmodule

bind merge_insertion_sorter msort_checker u_msort_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

// File: tb/tb_top.sv
// testbench for the merge-insertion sorter: sends sets of values, predicts sorted runs
// depends on msort_pkg and merge_insertion_sorter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    typedef struct packed {
        logic [msort_pkg::VAL_W-1:0] value;
        logic                        last;
        logic                        ovf;
    } sorted_item_t;

    sorted_item_t sorted_q[$];
    logic [msort_pkg::VAL_W-1:0] held_vals[$];
    bit held_ovf;
    int errors;
    int idle_cycles = 0;
    bit hold_off;

    merge_insertion_sorter u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // the result of merge-insertion is plain ascending order, duplicates kept
    task automatic close_set();
        logic [msort_pkg::VAL_W-1:0] run[$];
        sorted_item_t it;
        run = held_vals;
        run.sort();
        foreach (run[k]) begin
            it.value = run[k];
            it.last  = (k == run.size() - 1);
            it.ovf   = held_ovf;
            sorted_q = {sorted_q, it};
        end
        held_vals.delete();
        held_ovf = 1'b0;
    endtask

    // valid stays high between items sent back to back
    task automatic send_item(input logic [msort_pkg::VAL_W-1:0] v, input bit last,
                             input bit nogap = 1'b0);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (held_vals.size() < msort_pkg::MAX_ITEMS) held_vals = {held_vals, v};
        else held_ovf = 1'b1;
        if (last) close_set();
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sorted_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_set(input int n, input int mode);
        logic [msort_pkg::VAL_W-1:0] v;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: v = msort_pkg::VAL_W'($urandom());
                1: v = msort_pkg::VAL_W'($urandom_range(0, 7));
                2: v = msort_pkg::VAL_W'(i);
                default: v = msort_pkg::VAL_W'(n - i);
            endcase
            send_item(v, i == n - 1);
        end
    endtask

    task automatic test_directed();
        send_item('0, 1'b1);
        send_item({msort_pkg::VAL_W{1'b1}}, 1'b1);
        send_item({msort_pkg::VAL_W{1'b1}}, 1'b0);
        send_item('0, 1'b1);
        send_item(msort_pkg::VAL_W'(5), 1'b0);
        send_item(msort_pkg::VAL_W'(5), 1'b0);
        send_item(msort_pkg::VAL_W'(5), 1'b1);
        send_set(7, 3);
        send_set(6, 2);
        wait_drain();
    endtask

    task automatic test_overflow();
        send_set(msort_pkg::MAX_ITEMS, 0);
        // full store, closing item dropped
        for (int i = 0; i < msort_pkg::MAX_ITEMS + 2; i++)
            send_item(msort_pkg::VAL_W'($urandom()), i == msort_pkg::MAX_ITEMS + 1, 1'b1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 40; i++)
            send_item(msort_pkg::VAL_W'($urandom()), i % 10 == 9, 1'b1);
        wait_drain();
    endtask

    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 130) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, msort_pkg::MAX_ITEMS)
                                            : $urandom_range(1, 12);
            send_set(n, $urandom_range(0, 3));
            sent += n;
            if ($urandom_range(0, 7) == 0) wait_drain();
        end
        wait_drain();
    endtask

    // receiver with random stalls; one long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_q.size() == 0) begin
                $display("%0t unexpected item: expected none, actual %h last %b ovf %b",
                         $realtime, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                sorted_item_t e;
                e = sorted_q.pop_front();
                if (m_tdata !== {1'b0, e.value} || m_tlast !== e.last || m_tuser !== e.ovf) begin
                    $display("%0t mismatch: expected %h last %b ovf %b, actual %h last %b ovf %b",
                             $realtime, {1'b0, e.value}, e.last, e.ovf,
                             m_tdata, m_tlast, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        hold_off = 0;
        held_ovf = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        repeat (200) @(posedge aclk);
        if (errors == 0 && sorted_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
